@@ hw/rtl/e2c_pkg.sv @@
// Shared types, constants and month table for the epoch-to-calendar converter.
package e2c_pkg;

    // Fixed offsets and subtraction steps in seconds, then year and month constants
    localparam logic [31:0] EPOCH_2000       = 32'd946684800;
    localparam logic [31:0] SPAN_2100        = 32'd3155760000;
    localparam logic [31:0] SECS_PER_4Y      = 32'd126230400;
    localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
    localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
    localparam logic [31:0] SECS_PER_10MIN   = 32'd600;
    localparam logic [31:0] SECS_PER_MIN     = 32'd60;
    localparam logic [11:0] BASE_YEAR        = 12'd2000;
    localparam logic [11:0] LAST_YEAR        = 12'd2099;
    localparam logic [3:0]  MONTH_JAN        = 4'd1;
    localparam logic [3:0]  MONTH_FEB        = 4'd2;
    localparam logic [3:0]  MONTH_DEC        = 4'd12;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OFFSET,
        PH_RANGE,
        PH_YEAR4,
        PH_YEAR1,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MIN10,
        PH_MIN1,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        oor;
    } date_t;

    // Days in a month, February lengthened in leap years
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            unique case (month)
                MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Seconds in a month, February lengthened in leap years
    function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
        logic [31:0] secs;
        begin
            unique case (month)
                MONTH_FEB:                 secs = leap ? 32'd2505600 : 32'd2419200;
                4'd4, 4'd6, 4'd9, 4'd11:   secs = 32'd2592000;
                default:                   secs = 32'd2678400;
            endcase
            return secs;
        end
    endfunction

endpackage

@@ hw/rtl/e2c_alu.sv @@
// Shared 32-bit subtract and compare unit.
module e2c_alu (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] diff,
    output logic        ge
);
    logic [32:0] wide;

    // Subtract with borrow; no borrow means op_a >= op_b
    assign wide = {1'b0, op_a} - {1'b0, op_b};
    assign diff = wide[31:0];
    assign ge   = ~wide[32];

endmodule

@@ hw/rtl/e2c_core.sv @@
// Sequencer and datapath: offset, range check, then a subtract walk down to minutes.
module e2c_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     unix_seconds,
    input  logic            take,
    output logic            idle,
    output logic            done,
    output e2c_pkg::date_t  result
);
    import e2c_pkg::*;

    phase_t      state_reg, state_next;
    logic [31:0] val_reg, val_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic        oor_reg, oor_next;

    logic [31:0] op_b, diff;
    logic        ge;
    logic        leap;

    e2c_alu u_alu (
        .op_a (val_reg),
        .op_b (op_b),
        .diff (diff),
        .ge   (ge)
    );

    // Years 2000..2099: leap exactly when divisible by four
    assign leap = (year_reg[1:0] == 2'b00);

    // Next state, step selection and datapath updates
    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        oor_next   = oor_reg;
        op_b       = EPOCH_2000;

        unique case (state_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    val_next   = unix_seconds;
                    state_next = PH_OFFSET;
                end
            end
            PH_OFFSET, PH_RANGE:
            begin
                op_b = (state_reg == PH_OFFSET) ? EPOCH_2000 : SPAN_2100;
                if ((state_reg == PH_OFFSET) ? !ge : ge)
                begin
                    // Outside 2000..2099: report the base date
                    oor_next   = 1'b1;
                    val_next   = '0;
                    year_next  = BASE_YEAR;
                    month_next = MONTH_JAN;
                    day_next   = '0;
                    hour_next  = '0;
                    min_next   = '0;
                    state_next = PH_DONE;
                end
                else if (state_reg == PH_OFFSET)
                begin
                    val_next   = diff;
                    state_next = PH_RANGE;
                end
                else
                begin
                    oor_next   = 1'b0;
                    year_next  = BASE_YEAR;
                    month_next = MONTH_JAN;
                    day_next   = '0;
                    hour_next  = '0;
                    min_next   = '0;
                    state_next = PH_YEAR4;
                end
            end
            PH_YEAR4:
            begin
                // Drop whole four-year blocks
                op_b = SECS_PER_4Y;
                if (ge)
                begin
                    val_next  = diff;
                    year_next = year_reg + 12'd4;
                end
                else
                begin
                    state_next = PH_YEAR1;
                end
            end
            PH_YEAR1:
            begin
                op_b = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
                if (ge)
                begin
                    val_next  = diff;
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    state_next = PH_MONTH;
                end
            end
            PH_MONTH:
            begin
                // December takes whatever is left
                op_b = month_secs(month_reg, leap);
                if (ge && (month_reg != MONTH_DEC))
                begin
                    val_next   = diff;
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = PH_DAY;
                end
            end
            PH_DAY:
            begin
                op_b = SECS_PER_DAY;
                if (ge)
                begin
                    val_next = diff;
                    day_next = day_reg + 5'd1;
                end
                else
                begin
                    state_next = PH_HOUR;
                end
            end
            PH_HOUR:
            begin
                op_b = SECS_PER_HOUR;
                if (ge)
                begin
                    val_next  = diff;
                    hour_next = hour_reg + 5'd1;
                end
                else
                begin
                    state_next = PH_MIN10;
                end
            end
            PH_MIN10:
            begin
                // Tens of minutes first, then single minutes
                op_b = SECS_PER_10MIN;
                if (ge)
                begin
                    val_next = diff;
                    min_next = min_reg + 6'd10;
                end
                else
                begin
                    state_next = PH_MIN1;
                end
            end
            PH_MIN1:
            begin
                op_b = SECS_PER_MIN;
                if (ge)
                begin
                    val_next = diff;
                    min_next = min_reg + 6'd1;
                end
                else
                begin
                    state_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                if (take)
                begin
                    state_next = PH_IDLE;
                end
            end
            default:
            begin
                state_next = PH_IDLE;
            end
        endcase
    end

    // Hold the sequencer phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        oor_reg   <= oor_next;
    end

    assign idle          = (state_reg == PH_IDLE);
    assign done          = (state_reg == PH_DONE);
    assign result.year   = year_reg;
    assign result.month  = month_reg;
    assign result.day    = day_reg + 5'd1;
    assign result.hour   = hour_reg;
    assign result.minute = min_reg;
    assign result.second = val_reg[5:0];
    assign result.oor    = oor_reg;

`ifndef NO_ASSERTIONS
    // A request starts the offset step on the next cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_IDLE && start) |=> (state_reg == PH_OFFSET))
        else $error("request did not start conversion");

    // Single-year walk starts inside one four-year block
    a_year1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_YEAR1) |-> (val_reg < SECS_PER_4Y))
        else $error("four-year walk left too many seconds");

    // Finished date lies within the covered years and months
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_DONE) |-> (year_reg >= BASE_YEAR && year_reg <= LAST_YEAR
                                    && month_reg >= MONTH_JAN && month_reg <= MONTH_DEC))
        else $error("finished date out of range");

    // Day of month fits its month
    a_day: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_DONE) |-> (day_reg < month_len(month_reg, leap)))
        else $error("day exceeds month length");

    // Time of day fields stay within their ranges
    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_DONE) |-> (val_reg < SECS_PER_MIN && hour_reg < 5'd24
                                    && min_reg < 6'd60))
        else $error("time of day out of range");
`endif

endmodule

@@ hw/rtl/epoch_seconds_to_calendar_date_top.sv @@
// Top level: request handshake, conversion core and output register.
//
//  channel   signals                                    direction
//  --------  -----------------------------------------  ---------
//  request   in_valid, in_ready, unix_seconds           in
//  result    out_valid, out_ready, cal_year, cal_month,  out
//            cal_day, hour_of_day, minute_of_hour,
//            second_of_minute, out_of_range
//
//  An in-range request runs 2 range checks, then compare-and-subtract steps on the shared
//  32-bit subtractor: up to 25 four-year, 4 single-year, 12 month, 31 day, 24 hour and
//  16 minute steps, and 1 to load the result. A request before 2000 ends after the offset
//  check, one from 2100 onwards after the range check.
//  in_ready is high only while the core is idle; one request is in work at a time.
//  A finished result moves to the output register when that register is free or being taken.
//  Reset clears the sequencer and the result valid flag.
module epoch_seconds_to_calendar_date_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] unix_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] cal_year,
    output logic [3:0]  cal_month,
    output logic [4:0]  cal_day,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute,
    output logic        out_of_range
);
    import e2c_pkg::*;

    logic  core_idle;
    logic  core_done;
    logic  take;
    date_t core_result;
    date_t res_reg;
    logic  out_valid_reg, out_valid_next;

    e2c_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_valid),
        .unix_seconds (unix_seconds),
        .take         (take),
        .idle         (core_idle),
        .done         (core_done),
        .result       (core_result)
    );

    assign in_ready = core_idle;

    // Load the output register when it is empty or being drained
    assign take = core_done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the finished result
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= core_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign cal_year         = res_reg.year;
    assign cal_month        = res_reg.month;
    assign cal_day          = res_reg.day;
    assign hour_of_day      = res_reg.hour;
    assign minute_of_hour   = res_reg.minute;
    assign second_of_minute = res_reg.second;
    assign out_of_range     = res_reg.oor;

endmodule

@@ tb/calendar_date_checker.sv @@
// Checker for the epoch-to-calendar converter: predicts each date and compares results.
module calendar_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] unix_seconds,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] cal_year,
    input  logic [3:0]  cal_month,
    input  logic [4:0]  cal_day,
    input  logic [4:0]  hour_of_day,
    input  logic [5:0]  minute_of_hour,
    input  logic [5:0]  second_of_minute,
    input  logic        out_of_range,
    output int          mismatches,
    output int          dates_awaited,
    output int          dates_checked,
    output int          dates_out_of_range,
    output int          leap_days_seen
);

    import e2c_pkg::*;

    localparam int unsigned FIRST_SECOND = 32'd946684800;
    localparam int unsigned END_SECOND   = 32'd4102444800;
    localparam int unsigned FIRST_YEAR   = 2000;
    localparam int unsigned FINAL_YEAR   = 2099;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] secs;
        date_t       date;
    } awaited_date_t;

    awaited_date_t awaited_dates[$];
    int            error_tally;
    int            checked_tally;
    int            oor_tally;
    int            leap_tally;

    function automatic bit gregorian_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input bit leap);
        case (m)
            2:          return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Work out the calendar date and time of day named by a Unix time
    function automatic date_t convert_seconds(input logic [31:0] secs);
        date_t       d;
        int unsigned t;
        int unsigned days;
        int unsigned y;
        int unsigned m;
        int unsigned ylen;
        int unsigned mlen;
        d.year   = 12'(FIRST_YEAR);
        d.month  = 4'd1;
        d.day    = 5'd1;
        d.hour   = 5'd0;
        d.minute = 6'd0;
        d.second = 6'd0;
        d.oor    = 1'b1;
        if (secs < FIRST_SECOND || secs >= END_SECOND)
            return d;
        t        = secs - FIRST_SECOND;
        d.second = 6'(t % 60);
        t        = t / 60;
        d.minute = 6'(t % 60);
        t        = t / 60;
        d.hour   = 5'(t % 24);
        days     = t / 24;
        // Walk the years, stopping at the last one covered
        y = FIRST_YEAR;
        while (y < FINAL_YEAR)
        begin
            ylen = gregorian_leap(y) ? 366 : 365;
            if (days < ylen)
                break;
            days = days - ylen;
            y++;
        end
        // Walk the months; December takes whatever is left
        m = 1;
        while (m < 12)
        begin
            mlen = month_days(m, gregorian_leap(y));
            if (days < mlen)
                break;
            days = days - mlen;
            m++;
        end
        d.year  = 12'(y);
        d.month = 4'(m);
        d.day   = 5'(days + 1);
        d.oor   = 1'b0;
        return d;
    endfunction

    // Match results against the oldest awaited date, then queue new requests
    always @(posedge clk or negedge rst_n)
    begin
        awaited_date_t want;
        date_t         got;
        string         bad;
        if (!rst_n)
        begin
            awaited_dates.delete();
            error_tally        = 0;
            checked_tally      = 0;
            oor_tally          = 0;
            leap_tally         = 0;
            mismatches         <= 0;
            dates_awaited      <= 0;
            dates_checked      <= 0;
            dates_out_of_range <= 0;
            leap_days_seen     <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{year: cal_year, month: cal_month, day: cal_day, hour: hour_of_day,
                        minute: minute_of_hour, second: second_of_minute, oor: out_of_range};
                if (awaited_dates.size() == 0)
                begin
                    error_tally++;
                    if (error_tally <= REPORT_LIMIT)
                        $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                                 $realtime, got.year, got.month, got.day, got.hour,
                                 got.minute, got.second, got.oor);
                end
                else
                begin
                    want = awaited_dates.pop_front();
                    checked_tally++;
                    if (want.date.oor)
                        oor_tally++;
                    else if (want.date.month == 4'd2 && want.date.day == 5'd29)
                        leap_tally++;
                    bad = "";
                    if (got.year !== want.date.year)     bad = {bad, " year"};
                    if (got.month !== want.date.month)   bad = {bad, " month"};
                    if (got.day !== want.date.day)       bad = {bad, " day"};
                    if (got.hour !== want.date.hour)     bad = {bad, " hour"};
                    if (got.minute !== want.date.minute) bad = {bad, " minute"};
                    if (got.second !== want.date.second) bad = {bad, " second"};
                    if (got.oor !== want.date.oor)       bad = {bad, " out_of_range"};
                    if (bad != "")
                    begin
                        error_tally++;
                        if (error_tally <= REPORT_LIMIT)
                        begin
                            $write(
                                "[%0t] mismatch on%s for %0d: expected %0d-%0d-%0d %0d:%0d:%0d",
                                $realtime, bad, want.secs,
                                want.date.year, want.date.month, want.date.day,
                                want.date.hour, want.date.minute, want.date.second);
                            $display(" oor=%0b, got %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                                     want.date.oor, got.year, got.month, got.day,
                                     got.hour, got.minute, got.second, got.oor);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_dates.push_back('{secs: unix_seconds,
                                          date: convert_seconds(unix_seconds)});
            mismatches         <= error_tally;
            dates_awaited      <= awaited_dates.size();
            dates_checked      <= checked_tally;
            dates_out_of_range <= oor_tally;
            leap_days_seen     <= leap_tally;
        end
    end

endmodule

@@ tb/tb_epoch_seconds_to_calendar_date_top.sv @@
// Testbench top: clock, reset, request stimulus, result stalls and the verdict.
module tb_epoch_seconds_to_calendar_date_top;

    localparam int RANDOM_REQUESTS = 850;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 120;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [31:0] unix_seconds = 32'd0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic        out_of_range;

    int mismatches;
    int dates_awaited;
    int dates_checked;
    int dates_out_of_range;
    int leap_days_seen;
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    always #4 clk = ~clk;

    epoch_seconds_to_calendar_date_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .unix_seconds     (unix_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .cal_year         (cal_year),
        .cal_month        (cal_month),
        .cal_day          (cal_day),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .out_of_range     (out_of_range)
    );

    calendar_date_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .unix_seconds       (unix_seconds),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .cal_year           (cal_year),
        .cal_month          (cal_month),
        .cal_day            (cal_day),
        .hour_of_day        (hour_of_day),
        .minute_of_hour     (minute_of_hour),
        .second_of_minute   (second_of_minute),
        .out_of_range       (out_of_range),
        .mismatches         (mismatches),
        .dates_awaited      (dates_awaited),
        .dates_checked      (dates_checked),
        .dates_out_of_range (dates_out_of_range),
        .leap_days_seen     (leap_days_seen)
    );

    // Unix time of a calendar date and time of day from 2000 onwards
    function automatic logic [31:0] seconds_at(input int unsigned y, input int unsigned mo,
                                               input int unsigned d, input int unsigned h,
                                               input int unsigned mi, input int unsigned s);
        longint unsigned days;
        int unsigned     yy;
        days = 0;
        for (yy = 2000; yy < y; yy++)
            days += (((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0)) ? 366 : 365;
        case (mo)
            1:       days += 0;
            2:       days += 31;
            3:       days += 59;
            4:       days += 90;
            5:       days += 120;
            6:       days += 151;
            7:       days += 181;
            8:       days += 212;
            9:       days += 243;
            10:      days += 273;
            11:      days += 304;
            default: days += 334;
        endcase
        if (mo > 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)))
            days += 1;
        days += d - 1;
        return 32'(64'd946684800 + days * 86400 + h * 3600 + mi * 60 + s);
    endfunction

    // Present one request, hold it until taken, then maybe idle a few cycles
    task automatic send_request(input logic [31:0] secs);
        int gap;
        in_valid     <= 1'b1;
        unix_seconds <= secs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = 0;
        if (!steady && $urandom_range(99) < 8)
            gap = $urandom_range(6, 1);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender off until every awaited date has come back
    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (dates_awaited != 0)
            @(posedge clk);
    endtask

    // Stall the result side now and then, except in the steady stretch
    always @(posedge clk)
        out_ready <= rst_n && (steady || $urandom_range(99) >= 8);

    // End the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int unsigned yr;
        int unsigned mon;
        logic [31:0] month_start;
        logic [31:0] secs;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: range edges, leap days, year and month turns, bit patterns
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        send_request(32'd946684799);
        send_request(seconds_at(2000, 1, 1, 0, 0, 0));
        send_request(seconds_at(2000, 1, 1, 23, 59, 59));
        send_request(seconds_at(2000, 2, 28, 12, 30, 30));
        send_request(seconds_at(2000, 2, 29, 0, 0, 0));
        send_request(seconds_at(2000, 3, 1, 0, 0, 0));
        send_request(seconds_at(2000, 12, 31, 23, 59, 59));
        send_request(seconds_at(2001, 1, 1, 0, 0, 0));
        send_request(seconds_at(2001, 2, 28, 23, 59, 59));
        send_request(seconds_at(2001, 3, 1, 0, 0, 0));
        send_request(seconds_at(2004, 2, 29, 6, 7, 8));
        send_request(seconds_at(2038, 1, 19, 3, 14, 7));
        send_request(32'h8000_0000);
        send_request(seconds_at(2050, 6, 30, 18, 45, 0));
        send_request(seconds_at(2096, 2, 29, 23, 59, 59));
        send_request(seconds_at(2099, 1, 1, 0, 0, 0));
        send_request(seconds_at(2099, 12, 31, 23, 59, 59));
        send_request(32'd4102444800);
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
        drain_results();

        // Random requests: mostly in range, many at month turns, some anywhere
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            steady = (n >= 300 && n < 450);
            if (n == 600)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 60)
                secs = $urandom_range(32'd4102444799, 32'd946684800);
            else if (pick < 85)
            begin
                yr          = $urandom_range(2099, 2000);
                mon         = $urandom_range(12, 1);
                month_start = seconds_at(yr, mon, 1, 0, 0, 0);
                case ($urandom_range(3))
                    0:       secs = month_start;
                    1:       secs = month_start - 1;
                    2:       secs = month_start - 1 - $urandom_range(86399);
                    default: secs = month_start + $urandom_range(86399);
                endcase
            end
            else
                secs = $urandom();
            send_request(secs);
        end
        steady = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d converted dates, %0d of them outside 2000 to 2099", dates_checked,
                 dates_out_of_range);
        $display("and %0d landing on 29 February, with stalls on both channels", leap_days_seen);
        if (mismatches == 0 && dates_awaited == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/e2c_pkg.sv
hw/rtl/e2c_alu.sv
hw/rtl/e2c_core.sv
hw/rtl/epoch_seconds_to_calendar_date_top.sv
tb/calendar_date_checker.sv
tb/tb_epoch_seconds_to_calendar_date_top.sv
